FILE: rtl/aonlt_pkg.sv
package aonlt_pkg;

	localparam int LOCKS    = 256;
	localparam int MAX_KEYS = 16;

	localparam int KEY_W   = $clog2(LOCKS);
	localparam int TXN_W   = 16;
	localparam int TOTAL_W = $clog2(LOCKS + 1);
	localparam int QIDX_W  = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
	localparam int QCNT_W  = $clog2(MAX_KEYS + 1);

	typedef enum logic [1:0] {
		OP_ACQUIRE = 2'd0,
		OP_RELEASE = 2'd1,
		OP_PROBE   = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		STAT_QUEUED   = 3'd0,
		STAT_GRANTED  = 3'd1,
		STAT_CONFLICT = 3'd2,
		STAT_OVERFLOW = 3'd3,
		STAT_RELEASED = 3'd4,
		STAT_PROBE    = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHK_RD,
		S_CHK_EV,
		S_SET,
		S_REL_RD,
		S_REL,
		S_KEY_RD,
		S_RESP
	} state_t;

	typedef struct packed {
		logic [1:0]       operation;
		logic [TXN_W-1:0] txn_id;
		logic [7:0]       key_index;
		logic             last;
	} req_t;

	typedef struct packed {
		logic [2:0]       status;
		logic             key_held;
		logic [TXN_W-1:0] key_owner;
		logic [8:0]       lock_count;
	} rsp_t;

	// sequencer to table
	typedef struct packed {
		logic             rd_en;
		logic [KEY_W-1:0] rd_key;
		logic             set_en;
		logic [KEY_W-1:0] set_key;
		logic [TXN_W-1:0] set_owner;
		logic             clr_en;
		logic [KEY_W-1:0] clr_key;
	} tbl_cmd_t;

	// table to sequencer
	typedef struct packed {
		logic               rd_held;
		logic [TXN_W-1:0]   rd_owner;
		logic [TOTAL_W-1:0] lock_count;
	} tbl_stat_t;

endpackage

FILE: rtl/aonlt_table.sv
module aonlt_table (
	input  logic                 clk,
	input  logic                 arst_n,
	input  aonlt_pkg::tbl_cmd_t  cmd,
	output aonlt_pkg::tbl_stat_t stat
);

	logic [aonlt_pkg::LOCKS-1:0]       held_q;
	logic [aonlt_pkg::TOTAL_W-1:0]     count_q;
	logic [aonlt_pkg::TXN_W-1:0]       owner_mem [aonlt_pkg::LOCKS];
	logic [aonlt_pkg::TXN_W-1:0]       rd_owner_q;
	logic                              rd_held_q;

	// held bits and count, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= '0;
			count_q <= '0;
		end else begin
			if (cmd.set_en && !held_q[cmd.set_key]) begin
				held_q[cmd.set_key] <= 1'b1;
				count_q             <= count_q + aonlt_pkg::TOTAL_W'(1);
			end else if (cmd.clr_en) begin
				held_q[cmd.clr_key] <= 1'b0;
				count_q             <= count_q - aonlt_pkg::TOTAL_W'(1);
			end
		end
	end

	// owner ids, only meaningful under a set held bit
	always_ff @(posedge clk) begin
		if (cmd.set_en) begin
			owner_mem[cmd.set_key] <= cmd.set_owner;
		end
		if (cmd.rd_en) begin
			rd_owner_q <= owner_mem[cmd.rd_key];
			rd_held_q  <= held_q[cmd.rd_key];
		end
	end

	assign stat.rd_held    = rd_held_q;
	assign stat.rd_owner   = rd_owner_q;
	assign stat.lock_count = count_q;

	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == aonlt_pkg::TOTAL_W'($countones(held_q)))
		else $error("held count out of step with held bits");

	a_no_set_and_clr: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.set_en && cmd.clr_en))
		else $error("set and clear issued together");

	a_clr_only_held: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_en |-> held_q[cmd.clr_key])
		else $error("clear of a free lock");

endmodule

FILE: rtl/all_or_nothing_lock_table.sv
// all-or-nothing lock table: 256 locks, each a held bit plus a 16-bit owner id
// req channel (req_valid / req_stall / req): one beat per operation
//   acquire beats queue one key each (up to 16); the beat with last set checks
//   every queued key and grants all of them or none
//   release frees a key held by the same txn_id, probe reports the holder
// rsp channel (rsp_valid / rsp_stall / rsp): exactly one beat per req beat,
//   in order, carrying status, the addressed key's holder and the held count
// steps from the accepting edge to rsp_valid:
//   queued acquire, probe: S_KEY_RD, S_RESP; release: S_REL_RD, S_REL, S_KEY_RD, S_RESP
//   last acquire: check walk (S_CHK_RD, S_CHK_EV per queued key), grant walk (S_SET
//   per key), S_KEY_RD, S_RESP; a conflict ends the check walk early, an overflow
//   skips both walks; the check walk uses the single owner-table read port, one key at a time
// req_stall is high while an item is in the sequencer; a new beat is taken
//   the cycle after the result is loaded into the output register
// a stalled rsp beat holds in the output register; the sequencer waits in its
//   final step until that register frees up
// reset: all locks free, queue empty, no result pending; no clearing pass
module all_or_nothing_lock_table (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  aonlt_pkg::req_t req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output aonlt_pkg::rsp_t rsp
);

	aonlt_pkg::state_t    state_q, state_d;
	aonlt_pkg::tbl_cmd_t  cmd;
	aonlt_pkg::tbl_stat_t tbl;

	// latched item
	logic [1:0]                 op_q;
	logic [aonlt_pkg::TXN_W-1:0] txn_q;
	logic [aonlt_pkg::KEY_W-1:0] key_q;
	logic                       last_q;
	aonlt_pkg::status_t         status_q, status_d;
	logic                       status_ld;

	// acquire queue
	logic [aonlt_pkg::KEY_W-1:0]  pend_q [aonlt_pkg::MAX_KEYS];
	logic [aonlt_pkg::QCNT_W-1:0] pcount_q;
	logic                         povf_q;
	logic [aonlt_pkg::QCNT_W-1:0] idx_q;
	logic [aonlt_pkg::QCNT_W-1:0] idx_nxt;
	logic [aonlt_pkg::KEY_W-1:0]  walk_key;
	logic                         idx_clr, idx_inc;
	logic                         q_full;

	// output register
	aonlt_pkg::rsp_t rsp_q;
	logic            rsp_valid_q;
	logic            rsp_ld;
	logic            q_clear;
	logic            accept;

	assign req_stall = (state_q != aonlt_pkg::S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign q_full    = (pcount_q == aonlt_pkg::QCNT_W'(aonlt_pkg::MAX_KEYS));
	assign idx_nxt   = idx_q + aonlt_pkg::QCNT_W'(1);
	assign walk_key  = pend_q[idx_q[aonlt_pkg::QIDX_W-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aonlt_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer
	always_comb begin
		state_d   = state_q;
		status_d  = status_q;
		status_ld = 1'b0;
		idx_clr   = 1'b0;
		idx_inc   = 1'b0;
		rsp_ld    = 1'b0;
		q_clear   = 1'b0;
		cmd       = '0;
		cmd.set_owner = txn_q;
		cmd.set_key   = walk_key;
		cmd.clr_key   = key_q;
		cmd.rd_key    = key_q;
		case (state_q)
			aonlt_pkg::S_IDLE: begin
				if (accept) begin
					status_ld = 1'b1;
					case (req.operation)
						aonlt_pkg::OP_ACQUIRE: begin
							if (!req.last) begin
								status_d = aonlt_pkg::STAT_QUEUED;
								state_d  = aonlt_pkg::S_KEY_RD;
							end else if (povf_q || q_full) begin
								status_d = aonlt_pkg::STAT_OVERFLOW;
								state_d  = aonlt_pkg::S_KEY_RD;
							end else begin
								status_d = aonlt_pkg::STAT_GRANTED;
								idx_clr  = 1'b1;
								state_d  = aonlt_pkg::S_CHK_RD;
							end
						end
						aonlt_pkg::OP_RELEASE: begin
							status_d = aonlt_pkg::STAT_RELEASED;
							state_d  = aonlt_pkg::S_REL_RD;
						end
						default: begin
							// probe, and the unused code behaves as one
							status_d = aonlt_pkg::STAT_PROBE;
							state_d  = aonlt_pkg::S_KEY_RD;
						end
					endcase
				end
			end
			aonlt_pkg::S_CHK_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_key = walk_key;
				state_d    = aonlt_pkg::S_CHK_EV;
			end
			aonlt_pkg::S_CHK_EV: begin
				if (tbl.rd_held && tbl.rd_owner != txn_q) begin
					status_ld = 1'b1;
					status_d  = aonlt_pkg::STAT_CONFLICT;
					state_d   = aonlt_pkg::S_KEY_RD;
				end else if (idx_nxt == pcount_q) begin
					idx_clr = 1'b1;
					state_d = aonlt_pkg::S_SET;
				end else begin
					idx_inc = 1'b1;
					state_d = aonlt_pkg::S_CHK_RD;
				end
			end
			aonlt_pkg::S_SET: begin
				cmd.set_en = 1'b1;
				if (idx_nxt == pcount_q) begin
					state_d = aonlt_pkg::S_KEY_RD;
				end else begin
					idx_inc = 1'b1;
				end
			end
			aonlt_pkg::S_REL_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = aonlt_pkg::S_REL;
			end
			aonlt_pkg::S_REL: begin
				cmd.clr_en = tbl.rd_held && (tbl.rd_owner == txn_q);
				state_d    = aonlt_pkg::S_KEY_RD;
			end
			aonlt_pkg::S_KEY_RD: begin
				// fresh look at the addressed key after any change
				cmd.rd_en = 1'b1;
				state_d   = aonlt_pkg::S_RESP;
			end
			aonlt_pkg::S_RESP: begin
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_ld  = 1'b1;
					q_clear = (op_q == aonlt_pkg::OP_ACQUIRE) && last_q;
					state_d = aonlt_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = aonlt_pkg::S_IDLE;
			end
		endcase
	end

	// queue control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcount_q <= '0;
			povf_q   <= 1'b0;
			idx_q    <= '0;
		end else begin
			if (accept && req.operation == aonlt_pkg::OP_ACQUIRE) begin
				if (q_full) begin
					povf_q <= 1'b1;
				end else begin
					pcount_q <= pcount_q + aonlt_pkg::QCNT_W'(1);
				end
			end else if (q_clear) begin
				// end of a set, granted or refused
				pcount_q <= '0;
				povf_q   <= 1'b0;
			end
			if (idx_clr) begin
				idx_q <= '0;
			end else if (idx_inc) begin
				idx_q <= idx_nxt;
			end
		end
	end

	// item and queue payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= req.operation;
			txn_q  <= req.txn_id;
			key_q  <= req.key_index[aonlt_pkg::KEY_W-1:0];
			last_q <= req.last;
			if (req.operation == aonlt_pkg::OP_ACQUIRE && !q_full) begin
				pend_q[pcount_q[aonlt_pkg::QIDX_W-1:0]] <=
					req.key_index[aonlt_pkg::KEY_W-1:0];
			end
		end
		if (status_ld) begin
			status_q <= status_d;
		end
		if (rsp_ld) begin
			rsp_q.status     <= status_q;
			rsp_q.key_held   <= tbl.rd_held;
			rsp_q.key_owner  <= tbl.rd_held ? tbl.rd_owner : '0;
			rsp_q.lock_count <= 9'(tbl.lock_count);
		end
	end

	// output beat handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_ld) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	aonlt_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (tbl)
	);

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pcount_q <= aonlt_pkg::QCNT_W'(aonlt_pkg::MAX_KEYS))
		else $error("acquire queue past its depth");

	a_count_moves_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(tbl.lock_count != $past(tbl.lock_count)) |->
			($past(state_q) == aonlt_pkg::S_SET || $past(state_q) == aonlt_pkg::S_REL))
		else $error("held count changed outside grant or release");

	a_rsp_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(state_q) == aonlt_pkg::S_RESP)
		else $error("result beat raised outside the result step");

	a_walk_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == aonlt_pkg::S_CHK_RD || state_q == aonlt_pkg::S_SET) |->
			(idx_q < pcount_q))
		else $error("key walk past the queued keys");

endmodule
